// ----- rtl/fixed_block_pool_next_fit_macros.svh -----
// ----------------------------------------------------------------------------
// fixed_block_pool_next_fit_macros : assertion macros
// Clocked assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_NEXT_FIT_MACROS_SVH
`define FIXED_BLOCK_POOL_NEXT_FIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FBPNF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define FBPNF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fbpnf_pkg.sv -----
// ----------------------------------------------------------------------------
// fbpnf_pkg : shared types and constants
// Sizes, request and status codes, and the unit count clamp.
// ----------------------------------------------------------------------------
package fbpnf_pkg;

  localparam int MAX_UNITS   = 256;
  localparam int MIN_UNITS   = 2;
  localparam int WORD_BITS   = 32;
  localparam int NUM_WORDS   = MAX_UNITS / WORD_BITS;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WADDR_W     = $clog2(NUM_WORDS);
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  // decoded request as it sits in the queue
  typedef struct packed {
    op_e                op;
    logic [WADDR_W-1:0] word;
    logic [BIT_W-1:0]   bit_sel;
  } req_t;

  // clamp the written unit count into the legal range
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n < CNT_W'(MIN_UNITS)) begin
      r = CNT_W'(MIN_UNITS);
    end else if (n > CNT_W'(MAX_UNITS)) begin
      r = CNT_W'(MAX_UNITS);
    end
    return r;
  endfunction

endpackage

// ----- rtl/fbpnf_front.sv -----
// ----------------------------------------------------------------------------
// fbpnf_front : request intake
// Decodes incoming requests and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module fbpnf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic                          s_op,
  input  logic [fbpnf_pkg::IDX_W-1:0]   s_index,
  output logic                          q_valid,
  output fbpnf_pkg::req_t               q_req,
  input  logic                          q_ready
);

  fbpnf_pkg::req_t                    entries [fbpnf_pkg::QDEPTH];
  logic [fbpnf_pkg::QPTR_W-1:0]       wr_ptr;
  logic [fbpnf_pkg::QPTR_W-1:0]       rd_ptr;
  logic [fbpnf_pkg::QCNT_W-1:0]       count;
  fbpnf_pkg::req_t                    req_in;
  logic                               push;
  logic                               pop;

  // split the index into map word and bit
  always_comb begin
    req_in.op      = fbpnf_pkg::op_e'(s_op);
    req_in.word    = s_index[fbpnf_pkg::IDX_W-1:fbpnf_pkg::BIT_W];
    req_in.bit_sel = s_index[fbpnf_pkg::BIT_W-1:0];
  end

  assign s_ready = (count != fbpnf_pkg::QCNT_W'(fbpnf_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_req   = entries[rd_ptr];
  assign push    = s_valid && s_ready;
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      // count holds when both or neither happen
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/fbpnf_back.sv -----
// ----------------------------------------------------------------------------
// fbpnf_back : allocation engine
// Owns the used map, rover and count; scans one map word per cycle.
// ----------------------------------------------------------------------------
module fbpnf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fbpnf_pkg::CNT_W-1:0]   cnt,
  input  logic                          q_valid,
  input  fbpnf_pkg::req_t               q_req,
  output logic                          q_ready,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic                          m_granted,
  output logic [fbpnf_pkg::IDX_W-1:0]   m_index,
  output logic [fbpnf_pkg::CNT_W-1:0]   m_count,
  output fbpnf_pkg::status_e            m_status
);

  localparam int WB = fbpnf_pkg::WORD_BITS;
  localparam int WA = fbpnf_pkg::WADDR_W;
  localparam int BW = fbpnf_pkg::BIT_W;
  localparam int IW = fbpnf_pkg::IDX_W;
  localparam int CW = fbpnf_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FREE = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } bstate_t;

  bstate_t state, state_next;

  // used map memory with per-row valid bits
  logic [WB-1:0]                    mem [fbpnf_pkg::NUM_WORDS];
  logic [fbpnf_pkg::NUM_WORDS-1:0]  row_valid;
  logic [WA-1:0]                    ra_addr, rb_addr;
  logic [WB-1:0]                    ra_data, rb_data;
  logic                             ra_ok, rb_ok;
  logic [WB-1:0]                    word_a, word_b;
  logic                             wr_en;
  logic [WA-1:0]                    wr_addr;
  logic [WB-1:0]                    wr_data;

  // allocator state
  logic [IW-1:0]  rover, rover_next;
  logic [CW-1:0]  in_use, in_use_next;

  // per-request working registers
  logic [IW-1:0]  start, start_next;
  logic [WA-1:0]  w0, w0_next;
  logic [WA-1:0]  wlast, wlast_next;
  logic [WA-1:0]  cur_w, cur_w_next;
  logic           phase_b, phase_b_next;
  logic [IW-1:0]  free_idx, free_idx_next;
  logic           res_granted, res_granted_next;
  logic [IW-1:0]  res_index, res_index_next;
  fbpnf_pkg::status_e res_status, res_status_next;

  // scan helpers
  logic [WB-1:0]  cand;
  logic           found;
  logic [BW-1:0]  fb;
  logic [IW-1:0]  gi;
  logic [CW-1:0]  gi_inc;
  logic [IW-1:0]  g;
  logic [IW-1:0]  start_calc;
  logic [CW-1:0]  cnt_m1;
  logic           out_free;
  logic           rover_busy;
  logic [IW-1:0]  q_idx;

  assign word_a   = ra_ok ? ra_data : '0;
  assign word_b   = rb_ok ? rb_data : '0;
  assign rb_addr  = rover[IW-1:BW];
  assign out_free = !m_valid || m_ready;
  assign cnt_m1   = cnt - CW'(1);
  assign q_idx    = {q_req.word, q_req.bit_sel};
  assign start_calc = ({1'b0, rover} < cnt) ? rover : '0;

  // free candidates of the word under scan, within the current search window
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      g = {cur_w, BW'(b)};
      cand[b] = !word_a[b] && ({1'b0, g} < cnt) &&
                (phase_b ? (g < start) : (g >= start));
    end
    found = |cand;
    fb = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (cand[b]) begin
        fb = BW'(b);
      end
    end
    gi     = {cur_w, fb};
    gi_inc = {1'b0, gi} + CW'(1);
  end

  assign rover_busy = (rover != free_idx) && word_b[rover[BW-1:0]];

  always_comb begin
    state_next       = state;
    rover_next       = rover;
    in_use_next      = in_use;
    start_next       = start;
    w0_next          = w0;
    wlast_next       = wlast;
    cur_w_next       = cur_w;
    phase_b_next     = phase_b;
    free_idx_next    = free_idx;
    res_granted_next = res_granted;
    res_index_next   = res_index;
    res_status_next  = res_status;
    q_ready          = 1'b0;
    ra_addr          = cur_w;
    wr_en            = 1'b0;
    wr_addr          = cur_w;
    wr_data          = word_a;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          res_granted_next = 1'b0;
          res_index_next   = '0;
          res_status_next  = fbpnf_pkg::ST_OK;
          if (q_req.op == fbpnf_pkg::OP_FREE) begin
            ra_addr       = q_req.word;
            free_idx_next = q_idx;
            state_next    = S_FREE;
          end else if (in_use >= cnt) begin
            res_status_next = fbpnf_pkg::ST_FULL;
            state_next      = S_EMIT;
          end else begin
            ra_addr      = start_calc[IW-1:BW];
            start_next   = start_calc;
            w0_next      = start_calc[IW-1:BW];
            wlast_next   = cnt_m1[IW-1:BW];
            cur_w_next   = start_calc[IW-1:BW];
            phase_b_next = 1'b0;
            state_next   = S_SCAN;
          end
        end
      end

      S_FREE: begin
        if (!word_a[free_idx[BW-1:0]]) begin
          res_status_next = fbpnf_pkg::ST_BAD_FREE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = free_idx[IW-1:BW];
          wr_data = word_a & ~(WB'(1) << free_idx[BW-1:0]);
          if (in_use != '0) begin
            in_use_next = in_use - CW'(1);
          end
          if (rover_busy) begin
            rover_next = ({1'b0, free_idx} >= cnt) ? '0 : free_idx;
          end
        end
        state_next = S_EMIT;
      end

      S_SCAN: begin
        if (found) begin
          wr_en            = 1'b1;
          wr_addr          = cur_w;
          wr_data          = word_a | (WB'(1) << fb);
          in_use_next      = in_use + CW'(1);
          rover_next       = (gi_inc >= cnt) ? '0 : gi_inc[IW-1:0];
          res_granted_next = 1'b1;
          res_index_next   = gi;
          state_next       = S_EMIT;
        end else if (!phase_b) begin
          if (cur_w == wlast) begin
            phase_b_next = 1'b1;
            cur_w_next   = '0;
          end else begin
            cur_w_next   = cur_w + 1'b1;
          end
          ra_addr = cur_w_next;
        end else if (cur_w == w0) begin
          res_status_next = fbpnf_pkg::ST_FULL;
          state_next      = S_EMIT;
        end else begin
          cur_w_next = cur_w + 1'b1;
          ra_addr    = cur_w_next;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      ra_ok     <= 1'b0;
      rb_ok     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      ra_ok <= row_valid[ra_addr];
      rb_ok <= row_valid[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rover   <= '0;
      in_use  <= '0;
      m_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rover  <= rover_next;
      in_use <= in_use_next;
      if (state == S_EMIT && out_free) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    start       <= start_next;
    w0          <= w0_next;
    wlast       <= wlast_next;
    cur_w       <= cur_w_next;
    phase_b     <= phase_b_next;
    free_idx    <= free_idx_next;
    res_granted <= res_granted_next;
    res_index   <= res_index_next;
    res_status  <= res_status_next;
    if (state == S_EMIT && out_free) begin
      m_granted <= res_granted;
      m_index   <= res_index;
      m_count   <= in_use;
      m_status  <= res_status;
    end
  end

endmodule

// ----- rtl/fixed_block_pool_next_fit.sv -----
// ----------------------------------------------------------------------------
// fixed_block_pool_next_fit : next-fit allocator for a pool of equal units
// Hands out and takes back unit indexes of a 256-unit pool, one result each.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. An allocate takes the unit at the
// rover if free, else the first free unit searching forward from the rover and
// wrapping at the unit count; the rover then moves one past it. A free clears
// the unit's used bit and pulls the rover back to it when the rover's unit is
// still taken. Freeing a unit that is not in use reports a bad free and leaves
// everything alone; an allocate on a full pool reports pool full. Requests go
// into a two-entry queue and are worked off by the engine one at a time; the
// engine's result sits in an output register, so new requests are taken while
// a result waits. A free passes the idle, free and emit states, an allocate on
// a full pool passes idle and emit, any other allocate passes idle, one scan
// step per 32-unit map word (up to nine word reads, as the start word is read
// again after the wrap) and emit; the scan rate is set by the scan read port of
// the used map memory, which returns one 32-bit word per cycle. The used map is
// cleared at reset through per-word valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_block_pool_next_fit (
  input  logic        clk,
  input  logic        rst,
  // config: unit count register
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] free_index
  input  logic [0:0]  s_axis_tuser,   // [0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] unit_index, [16:8] used_count, rest zero
  output logic [2:0]  m_axis_tuser    // [0] granted, [2:1] status
);

  logic [fbpnf_pkg::CNT_W-1:0]   unit_count;
  logic [fbpnf_pkg::CNT_W-1:0]   cnt;
  logic                          q_valid;
  logic                          q_ready;
  fbpnf_pkg::req_t               q_req;
  logic                          m_granted;
  logic [fbpnf_pkg::IDX_W-1:0]   m_index;
  logic [fbpnf_pkg::CNT_W-1:0]   m_count;
  fbpnf_pkg::status_e            m_status;

  // unit count register, clamped before use
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_count <= fbpnf_pkg::CNT_W'(fbpnf_pkg::MAX_UNITS);
    end else if (cfg_we) begin
      unit_count <= cfg_data;
    end
  end

  assign cnt = fbpnf_pkg::eff_count(unit_count);

  // intake and decode
  fbpnf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_op    (s_axis_tuser[0]),
    .s_index (s_axis_tdata),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_ready (q_ready)
  );

  // allocation engine with the used map
  fbpnf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cnt       (cnt),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_ready   (q_ready),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_granted (m_granted),
    .m_index   (m_index),
    .m_count   (m_count),
    .m_status  (m_status)
  );

  // pack the result fields, low field first
  assign m_axis_tdata = {
    (fbpnf_pkg::OUT_TDATA_W - fbpnf_pkg::CNT_W - fbpnf_pkg::IDX_W)'(0),
    m_count,
    m_index
  };
  assign m_axis_tuser = {m_status, m_granted};

endmodule

// ----- rtl/fbpnf_checker.sv -----
// ----------------------------------------------------------------------------
// fbpnf_checker : port-level checks
// Watches the result stream of the allocator for inconsistent results.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_next_fit_macros.svh"

module fbpnf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser
);

  // a grant is always ok and leaves at least one unit in use
  `FBPNF_ASSERT_IMP(a_grant_ok,
    m_axis_tvalid && m_axis_tuser[0],
    (m_axis_tuser[2:1] == 2'd0) && (m_axis_tdata[16:8] != 9'd0),
    "grant with bad status or zero count")

  // no grant means index zero
  `FBPNF_ASSERT_IMP(a_nogrant_idx,
    m_axis_tvalid && !m_axis_tuser[0],
    m_axis_tdata[7:0] == 8'd0,
    "unit index set without a grant")

  // count bounded, padding clear, status legal
  `FBPNF_ASSERT_IMP(a_fields_legal,
    m_axis_tvalid,
    (m_axis_tdata[16:8] <= 9'd256) && (m_axis_tdata[23:17] == 7'd0) &&
    (m_axis_tuser[2:1] != 2'd3),
    "result fields out of range")

  // a stalled result holds
  `FBPNF_ASSERT_NXT(a_out_hold,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result changed while stalled")

endmodule

bind fixed_block_pool_next_fit fbpnf_checker u_checker (.*);

// ----- tb/tb_fixed_block_pool_next_fit.sv -----
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_next_fit : self-checking bench for the next-fit pool
// Drives allocate and free requests through the request stream, predicts
// every result from a bench-side model of the used map, rover and count,
// and checks each result field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_next_fit;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 10;
  // idle tail after the last owed result, so a stray result still gets flagged
  localparam int TAIL_CYCLES  = 40;

  // one result as it travels on the result stream
  typedef struct packed {
    logic                          granted;
    logic [fbpnf_pkg::IDX_W-1:0]   unit_index;
    logic [fbpnf_pkg::CNT_W-1:0]   used_count;
    fbpnf_pkg::status_e            status;
  } pool_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [8:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] free_index
  logic [0:0]  s_axis_tuser;   // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] unit_index, [16:8] used_count, rest zero
  logic [2:0]  m_axis_tuser;   // [0] granted, [2:1] status

  fixed_block_pool_next_fit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // bench-side copy of the pool state
  // --------------------------------------------------------------------------
  logic [fbpnf_pkg::MAX_UNITS-1:0] taken_map;
  int unsigned                     rover_pos;
  int unsigned                     held_units;
  logic [8:0]                      size_reg;

  // results still owed by the block, oldest first
  pool_result_t pending_results[$];

  int mismatch_count;
  int cycle_count;

  // pacing controls shared by the tests, the request tasks and the result pacing
  bit sender_steady;
  bit receiver_steady;
  int hold_off_left;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // written size clamped into 2..MAX_UNITS
  function automatic int unsigned pool_limit();
    int unsigned n;
    n = size_reg;
    if (n < fbpnf_pkg::MIN_UNITS) begin
      n = fbpnf_pkg::MIN_UNITS;
    end else if (n > fbpnf_pkg::MAX_UNITS) begin
      n = fbpnf_pkg::MAX_UNITS;
    end
    return n;
  endfunction

  // applies one request to the pool state and returns the result it causes
  function automatic pool_result_t predict_pool_request(input fbpnf_pkg::op_e op,
                                                        input logic [7:0] idx);
    pool_result_t res;
    int unsigned  lim;
    int unsigned  start;
    int unsigned  pos;
    int unsigned  i;
    bit           found;
    res   = '0;
    lim   = pool_limit();
    found = 1'b0;
    if (op == fbpnf_pkg::OP_ALLOC) begin
      res.status = fbpnf_pkg::ST_FULL;
      if (held_units < lim) begin
        // a rover left past a lowered size starts the search at zero
        start = (rover_pos < lim) ? rover_pos : 0;
        for (i = 0; i < lim && !found; i++) begin
          pos = start + i;
          if (pos >= lim) begin
            pos -= lim;
          end
          if (!taken_map[pos]) begin
            taken_map[pos] = 1'b1;
            held_units++;
            rover_pos = pos + 1;
            if (rover_pos >= lim) begin
              rover_pos = 0;
            end
            res.granted    = 1'b1;
            res.unit_index = (fbpnf_pkg::IDX_W)'(pos);
            res.status     = fbpnf_pkg::ST_OK;
            found          = 1'b1;
          end
        end
      end
    end else begin
      if (!taken_map[idx]) begin
        res.status = fbpnf_pkg::ST_BAD_FREE;
      end else begin
        taken_map[idx] = 1'b0;
        if (held_units > 0) begin
          held_units--;
        end
        // rover sitting on a taken unit is pulled back to the freed one
        if (taken_map[rover_pos]) begin
          rover_pos = idx;
          if (rover_pos >= lim) begin
            rover_pos = 0;
          end
        end
        res.status = fbpnf_pkg::ST_OK;
      end
    end
    res.used_count = (fbpnf_pkg::CNT_W)'(held_units);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // idle cycles after a request: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_steady || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // offers one request, waits for it to be taken, records its result
  task automatic send_request(input fbpnf_pkg::op_e op, input logic [7:0] idx);
    int gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_pool_request(op, idx));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stops offering and waits until every owed result has come back
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // unit count write, only with the block idle
  task automatic write_pool_size(input logic [8:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    size_reg = value;
  endtask

  // random unit among those currently taken
  function automatic logic [7:0] pick_taken_unit();
    int unsigned k;
    int unsigned i;
    k = $urandom_range(0, $countones(taken_map) - 1);
    for (i = 0; i < fbpnf_pkg::MAX_UNITS; i++) begin
      if (taken_map[i]) begin
        if (k == 0) begin
          return 8'(i);
        end
        k--;
      end
    end
    return 8'd0;
  endfunction

  // mostly allocates and frees of taken units, a few frees of random units
  task automatic send_random_request(input int alloc_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      // free_index is ignored on allocate but still toggled
      send_request(fbpnf_pkg::OP_ALLOC, 8'($urandom_range(0, 255)));
    end else if (r < 95 && taken_map != '0) begin
      send_request(fbpnf_pkg::OP_FREE, pick_taken_unit());
    end else begin
      send_request(fbpnf_pkg::OP_FREE, 8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random tready, with an optional long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : result_pacing
    int r;
    int stall_left;
    if (hold_off_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left--;
    end else if (receiver_steady) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        stall_left = $urandom_range(10, 40);
      end
      m_axis_tready <= (r >= 25);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("mismatch at cycle %0d: %s expected %0d, got %0d",
                 cycle_count, name, want, got);
      end
    end
  endtask

  // every accepted result against the oldest owed one
  always @(posedge clk) begin : result_check
    pool_result_t want;
    pool_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.granted    = m_axis_tuser[0];
      got.unit_index = m_axis_tdata[7:0];
      got.used_count = m_axis_tdata[16:8];
      got.status     = fbpnf_pkg::status_e'(m_axis_tuser[2:1]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("mismatch at cycle %0d: result with no request pending", cycle_count);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("granted", want.granted, got.granted);
        check_field("unit_index", want.unit_index, got.unit_index);
        check_field("used_count", want.used_count, got.used_count);
        check_field("status", int'(want.status), int'(got.status));
      end
    end
  end

  // cycle counter and run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // smallest pool, pool full, bad frees, lowered size with rover and units past it
  task automatic test_corner_cases();
    // size 0 clamps to the minimum of two units
    write_pool_size(9'd0);
    send_request(fbpnf_pkg::OP_ALLOC, 8'hff);
    send_request(fbpnf_pkg::OP_ALLOC, 8'h00);
    send_request(fbpnf_pkg::OP_ALLOC, 8'h00);   // pool full
    send_request(fbpnf_pkg::OP_FREE, 8'd255);   // never taken, bad free
    send_request(fbpnf_pkg::OP_FREE, 8'd0);
    send_request(fbpnf_pkg::OP_FREE, 8'd0);     // already free, bad free
    send_request(fbpnf_pkg::OP_ALLOC, 8'h00);
    send_request(fbpnf_pkg::OP_FREE, 8'd1);
    send_request(fbpnf_pkg::OP_FREE, 8'd0);
    // all ones clamps to the full pool
    write_pool_size(9'd511);
    repeat (5) send_request(fbpnf_pkg::OP_ALLOC, 8'h00);
    // rover now past the lowered size, units 3, 4 and 5 beyond it
    write_pool_size(9'd3);
    send_request(fbpnf_pkg::OP_ALLOC, 8'h00);   // full, units past the size still count
    send_request(fbpnf_pkg::OP_FREE, 8'd4);     // unit past the size may be freed
    send_request(fbpnf_pkg::OP_FREE, 8'd1);
    send_request(fbpnf_pkg::OP_FREE, 8'd2);
    send_request(fbpnf_pkg::OP_ALLOC, 8'h00);   // search starts at zero, gets unit 0
    send_request(fbpnf_pkg::OP_ALLOC, 8'h00);   // full, units 3 and 5 past the size still count
    send_request(fbpnf_pkg::OP_FREE, 8'd3);     // rover unit 1 is free, rover stays
    send_request(fbpnf_pkg::OP_ALLOC, 8'h00);   // search from the rover gets unit 1
    send_request(fbpnf_pkg::OP_FREE, 8'd0);     // rover unit 2 is free, rover stays
    send_request(fbpnf_pkg::OP_ALLOC, 8'h00);
  endtask

  // random traffic over several pool sizes, fill-heavy and drain-heavy
  task automatic test_random_phases();
    logic [8:0] sizes[8]     = '{9'd256, 9'd256, 9'd2, 9'd1, 9'd37, 9'd257, 9'd16, 9'd200};
    int         lengths[8]   = '{230, 150, 60, 40, 150, 100, 100, 130};
    int         alloc_pct[8] = '{88, 25, 50, 50, 55, 50, 60, 70};
    int         p;
    for (p = 0; p < 8; p++) begin
      write_pool_size(sizes[p]);
      repeat (lengths[p]) send_random_request(alloc_pct[p]);
    end
  endtask

  // result side held off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    wait_for_results();
    hold_off_left = 300;
    sender_steady = 1'b1;
    repeat (30) send_random_request(60);
    sender_steady = 1'b0;
  endtask

  // sender pauses for a full drain, then both sides run with no idling
  task automatic test_back_to_back();
    wait_for_results();
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    repeat (40) send_random_request(55);
    wait_for_results();
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = 9'd0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'd0;
    s_axis_tuser    = fbpnf_pkg::OP_ALLOC;
    m_axis_tready   = 1'b0;
    mismatch_count  = 0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    hold_off_left   = 0;
    taken_map       = '0;
    rover_pos       = 0;
    held_units      = 0;
    size_reg        = 9'd256;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_cases();
    test_random_phases();
    test_output_backpressure();
    test_back_to_back();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
